### hdl/orm_pkg.sv
// ----------------------------------------------------------------------------
// orm_pkg: shared types and constants of the outlier rejecting mean
// Transaction payloads, the controller/datapath command and status groups,
// and the acceptance factor of each pass.
// ----------------------------------------------------------------------------
`default_nettype none

package orm_pkg;

	localparam int NUM_PASSES = 4;

	localparam logic [2:0] FACTOR_PASS0 = 3'd5;
	localparam logic [2:0] FACTOR_PASS1 = 3'd4;
	localparam logic [2:0] FACTOR_PASS2 = 3'd3;
	localparam logic [2:0] FACTOR_PASS3 = 3'd3;

	typedef struct packed {
		logic [31:0] sample_value;
		logic        last_sample;
	} sample_t;

	typedef struct packed {
		logic [31:0] final_average;
		logic [10:0] accepted_count;
		logic        none_accepted;
		logic        store_overflow;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;        // sample transaction accepted
		logic       pass_init;   // set reference, clear the pass sums
		logic       first_pass;  // reference comes from the trial average
		logic [1:0] pass;        // current pass number
		logic       rd_issue;    // read the next stored sample
		logic       pass_end;    // pass sums are complete
		logic       avg_update;  // take the divider quotient as the average
		logic       clear_set;   // result delivered, start a new set
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;  // the read being issued is the last stored sample
		logic cnt_zero;   // the pass has accepted no sample
		logic div_done;   // quotient is ready
	} status_t;

	function automatic logic [2:0] pass_factor(input logic [1:0] pass);
		logic [2:0] f;
		case (pass)
			2'd0:    f = FACTOR_PASS0;
			2'd1:    f = FACTOR_PASS1;
			2'd2:    f = FACTOR_PASS2;
			2'd3:    f = FACTOR_PASS3;
			default: f = FACTOR_PASS3;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

### hdl/orm_ram.sv
// ----------------------------------------------------------------------------
// orm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/orm_div.sv
// ----------------------------------------------------------------------------
// orm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_div #(
	parameter int NW = 43,
	parameter int DW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output      logic          done,
	output      logic [NW-1:0] quotient
);

	localparam int CNTW = $clog2(NW + 1);

	logic            run_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dsr_q;
	logic            done_q;

	logic [DW:0] trial_rem;
	logic [DW:0] diff;
	logic        ge;

	assign trial_rem = {rem_q, quo_q[NW-1]};
	assign ge        = trial_rem >= {1'b0, dsr_q};
	assign diff      = trial_rem - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial_rem[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### hdl/orm_datapath.sv
// ----------------------------------------------------------------------------
// orm_datapath: sample store, acceptance test, pass sums and average
// Executes the controller's commands; reports scan, count and divider status.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_datapath #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire orm_pkg::cmd_t     cmd,
	output      orm_pkg::status_t  status,
	input  wire logic [31:0]       sample_value,
	input  wire logic [31:0]       trial,
	output      orm_pkg::result_t  result
);

	import orm_pkg::*;

	localparam int SW   = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int SUMW = SW + CW;
	localparam int FW   = SW + 3;

	logic [CW-1:0]   count_q;
	logic            ovf_q;
	logic            empty_q;
	logic [SW-1:0]   avg_q;
	logic [FW-1:0]   fp_q;
	logic [SUMW-1:0] sum_q;
	logic [CW-1:0]   acc_q;
	logic [AW-1:0]   rd_idx_q;
	logic            rd_s1;

	logic            full;
	logic [2:0]      factor;
	logic [SW-1:0]   ref_avg;
	logic [SW-1:0]   rdata;
	logic [FW-1:0]   fx;
	logic            hit;
	logic            div_done;
	logic [SUMW-1:0] quotient;

	assign full    = count_q == CW'(MAX_SAMPLES);
	assign factor  = pass_factor(cmd.pass);
	assign ref_avg = cmd.first_pass ? trial[SW-1:0] : avg_q;
	assign fx      = FW'(rdata) * FW'(factor);

	// Accept when both values are nonzero and each is below factor times the other.
	assign hit = rd_s1 && (rdata != '0) && (avg_q != '0)
		&& (FW'(rdata) < fp_q) && (FW'(avg_q) < fx);

	orm_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (cmd.load && !full),
		.waddr(count_q[AW-1:0]),
		.wdata(sample_value[SW-1:0]),
		.re   (cmd.rd_issue),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	orm_div #(
		.NW(SUMW),
		.DW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.pass_end && (acc_q != '0)),
		.dividend(sum_q),
		.divisor (acc_q),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			empty_q  <= 1'b0;
			rd_idx_q <= '0;
			rd_s1    <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_issue;
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.pass_init) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_issue) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
			if (cmd.pass_end && (acc_q == '0)) begin
				empty_q <= 1'b1;
			end
			if (cmd.clear_set) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				empty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_init) begin
			avg_q <= ref_avg;
			fp_q  <= FW'(ref_avg) * FW'(factor);
			sum_q <= '0;
			acc_q <= '0;
		end else begin
			if (hit) begin
				sum_q <= sum_q + SUMW'(rdata);
				acc_q <= acc_q + CW'(1);
			end
			if (cmd.avg_update) begin
				avg_q <= quotient[SW-1:0];
			end
		end
	end

	assign status.scan_last = CW'(rd_idx_q) == (count_q - CW'(1));
	assign status.cnt_zero  = acc_q == '0;
	assign status.div_done  = div_done;

	assign result.final_average  = 32'(avg_q);
	assign result.accepted_count = 11'(acc_q);
	assign result.none_accepted  = empty_q;
	assign result.store_overflow = ovf_q;

endmodule

`default_nettype wire

### hdl/orm_ctrl.sv
// ----------------------------------------------------------------------------
// orm_ctrl: sequencing controller
// Loads samples, then steps through the four passes and delivers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             last,
	input  wire orm_pkg::status_t status,
	output      orm_pkg::cmd_t    cmd,
	output      logic             busy,
	output      logic             done
);

	import orm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_PEND  = 3'd4;
	localparam logic [2:0] ST_DIVW  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	localparam logic [1:0] LAST_PASS = 2'(NUM_PASSES - 1);

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] pass_q;
	logic [1:0] pass_d;

	always_comb begin
		state_d        = state_q;
		pass_d         = pass_q;
		cmd            = '0;
		cmd.pass       = pass_q;
		cmd.first_pass = pass_q == 2'd0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start && last) begin
					state_d = ST_INIT;
					pass_d  = 2'd0;
				end
			end
			ST_INIT: begin
				cmd.pass_init = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.rd_issue = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PEND;
			end
			ST_PEND: begin
				cmd.pass_end = 1'b1;
				if (!status.cnt_zero) begin
					state_d = ST_DIVW;
				end else if (pass_q == LAST_PASS) begin
					state_d = ST_DONE;
				end else begin
					pass_d  = pass_q + 2'd1;
					state_d = ST_INIT;
				end
			end
			ST_DIVW: begin
				if (status.div_done) begin
					cmd.avg_update = 1'b1;
					if (pass_q == LAST_PASS) begin
						state_d = ST_DONE;
					end else begin
						pass_d  = pass_q + 2'd1;
						state_d = ST_INIT;
					end
				end
			end
			ST_DONE: begin
				cmd.clear_set = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;

`ifndef SYNTHESIS
	a_divw_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PEND) && status.cnt_zero |=> state_q != ST_DIVW)
		else $error("divider wait entered for a pass with no accepted sample");
	a_done_after_last_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> pass_q == LAST_PASS)
		else $error("result delivered before the last pass");
	a_scan_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |=> state_q == ST_SCAN)
		else $error("pass set-up not followed by the scan");
`endif

endmodule

`default_nettype wire

### hdl/outlier_rejecting_mean.sv
// ----------------------------------------------------------------------------
// outlier_rejecting_mean: iterative ratio-clipped mean of timing samples
// Stores a set of samples, then runs four rejection passes and reports
// the final average together with its count and two flags.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// sample    in         start & !busy         orm_pkg::sample_t
// result    out        done (one cycle)      orm_pkg::result_t
// config    in         cfg_we                cfg_wdata (trial average)
//
// A sample transaction that is not the last of its set leaves busy low, so
// samples can be loaded back to back. The last sample starts the four
// passes; each pass reads the stored samples, one store read per cycle,
// and, if it accepted any, the bit-serial divider then works through the
// sum width SW + CW.
// The result is on the result port for the single cycle in which done is high,
// and busy falls in the cycle after. The receiver cannot stall the block.
// Reset clears the sample count, the flags and the trial average; the store
// itself is not cleared, as only entries written in the current set are read.
// ----------------------------------------------------------------------------
`default_nettype none

module outlier_rejecting_mean #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire orm_pkg::sample_t sample,
	output      logic             done,
	output      orm_pkg::result_t result,
	input  wire logic             cfg_we,
	input  wire logic [31:0]      cfg_wdata
);

	import orm_pkg::*;

	// Trial average: the reference for the first pass. It is kept across sets,
	// so it need only be written once.
	logic [31:0] trial_q;

	cmd_t    cmd;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trial_q <= '0;
		end else if (cfg_we) begin
			trial_q <= cfg_wdata;
		end
	end

	// The controller owns the sequence of passes; the datapath owns the
	// store, the acceptance test, the sums and the divider.
	orm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.last  (sample.last_sample),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	orm_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample_value(sample.sample_value),
		.trial       (trial_q),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while the block takes new samples");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");
	a_plain_sample_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !sample.last_sample |=> !busy)
		else $error("a sample that is not the last one started the passes");
	a_last_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && sample.last_sample |=> busy && !done)
		else $error("the last sample did not start the passes");
`endif

endmodule

`default_nettype wire

### tb/tb_outlier_rejecting_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_outlier_rejecting_mean: self-checking bench for the clipped mean block
// Feeds sample sets through the start/busy port while a clocked monitor
// predicts the four-pass ratio-clipped mean of each set and compares every
// field of the single result that the last sample of a set produces.
// ----------------------------------------------------------------------------

module tb_outlier_rejecting_mean;

	import orm_pkg::*;

	localparam int unsigned STORE_DEPTH    = 1024;
	localparam int unsigned WATCHDOG_LIMIT = 50000;

	// Acceptance factor of each of the four passes, in pass order.
	localparam int unsigned CLIP_FACTOR [NUM_PASSES] = '{5, 4, 3, 3};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	sample_t     sample    = '0;
	logic        done;
	result_t     result;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// Sample transactions still to be offered, and the results still owed.
	sample_t pending_samples [$];
	result_t expected_results [$];

	// Shadow of the block: the trial average register and the set being built.
	logic [31:0]  trial_copy = '0;
	logic [31:0]  set_store [STORE_DEPTH];
	int unsigned  set_len     = 0;
	bit           set_dropped = 1'b0;

	int unsigned  sender_idle_pct = 0;
	int unsigned  queued_items    = 0;
	int unsigned  fail_count      = 0;
	int unsigned  idle_cycles     = 0;

	outlier_rejecting_mean #(
		.MAX_SAMPLES(STORE_DEPTH),
		.SAMPLE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Runs the four clipping passes over the shadow set. The ratio test is done
	// by cross-multiplication in 64 bits, so that no product can wrap: a sample
	// x is kept against reference p when both are nonzero, x < F*p and p < F*x.
	// A pass that keeps nothing leaves the reference as it was and raises the
	// empty flag; its count of zero is what is reported if it is the last pass.
	function automatic result_t clipped_mean();
		logic [63:0] avg;
		logic [63:0] sum;
		logic [63:0] f;
		logic [63:0] x;
		int unsigned hits;
		int unsigned p;
		int unsigned i;
		bit          empty;
		result_t     r;
		avg   = {32'd0, trial_copy};
		empty = 1'b0;
		hits  = 0;
		for (p = 0; p < NUM_PASSES; p++) begin
			f    = CLIP_FACTOR[p];
			sum  = '0;
			hits = 0;
			for (i = 0; i < set_len; i++) begin
				x = {32'd0, set_store[i]};
				if (x != 0 && avg != 0 && x < f * avg && avg < f * x) begin
					sum  += x;
					hits++;
				end
			end
			if (hits != 0)
				avg = sum / hits;
			else
				empty = 1'b1;
		end
		r.final_average  = avg[31:0];
		r.accepted_count = 11'(hits);
		r.none_accepted  = empty;
		r.store_overflow = set_dropped;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
				$realtime, name, want, want, got, got);
			fail_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------------

	// The offer slot is free when nothing is offered or when the transaction
	// on the port is being taken at this edge. Only then may the next sample
	// be presented, or start dropped for an idle cycle; start is never lowered
	// and raised again within one step.
	always @(posedge clk) begin : driver
		if (arst_n && (!start || !busy)) begin
			if (pending_samples.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct) begin
				sample <= pending_samples.pop_front();
				start  <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor and scoreboard
	// ------------------------------------------------------------------------

	// Everything is sampled at the rising edge, before the block or the driver
	// update anything in that step. A result is checked before the sample of
	// the same edge is recorded, although busy stays high while done is high,
	// so the two never coincide in a correct block.
	always @(posedge clk) begin : monitor
		result_t want;
		bit      progress;
		progress = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				trial_copy = cfg_wdata;
				progress   = 1'b1;
			end
			if (done) begin
				progress = 1'b1;
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, actual avg %0d count %0d",
						$realtime, result.final_average, result.accepted_count);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("final_average", want.final_average,
						result.final_average);
					check_field("accepted_count", want.accepted_count,
						result.accepted_count);
					check_field("none_accepted", want.none_accepted,
						result.none_accepted);
					check_field("store_overflow", want.store_overflow,
						result.store_overflow);
				end
			end
			if (start && !busy) begin
				progress = 1'b1;
				// A full store drops the sample, the last one included, but
				// the passes still run when the last sample arrives.
				if (set_len < STORE_DEPTH) begin
					set_store[set_len] = sample.sample_value;
					set_len++;
				end else begin
					set_dropped = 1'b1;
				end
				if (sample.last_sample) begin
					expected_results.push_back(clipped_mean());
					set_len     = 0;
					set_dropped = 1'b0;
				end
			end
		end
		idle_cycles = progress ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	task automatic queue_item(input logic [31:0] value, input logic last);
		sample_t s;
		s.sample_value = value;
		s.last_sample  = last;
		pending_samples.push_back(s);
		queued_items++;
	endtask

	// A value within pct per cent of centre, either side, held to 32 bits.
	function automatic logic [31:0] around(input logic [31:0] centre,
			input int unsigned pct);
		logic [63:0] delta;
		logic [63:0] v;
		delta = (64'(centre) * $urandom_range(0, pct)) / 100;
		if ($urandom_range(0, 1))
			v = 64'(centre) + delta;
		else
			v = (delta > 64'(centre)) ? 64'd0 : 64'(centre) - delta;
		if (v > 64'hFFFF_FFFF)
			v = 64'hFFFF_FFFF;
		return v[31:0];
	endfunction

	// One set of n samples clustered round centre, with noise per cent of them
	// replaced by zeros, full-range values or low and high outliers.
	task automatic queue_set(input int unsigned n, input logic [31:0] centre,
			input int unsigned spread, input int unsigned noise);
		int unsigned k;
		logic [31:0] v;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < noise) begin
				case ($urandom_range(0, 3))
					0:       v = 32'd0;
					1:       v = $urandom();
					2:       v = centre >> $urandom_range(1, 4);
					default: v = around(centre, 600);
				endcase
			end else begin
				v = around(centre, spread);
			end
			queue_item(v, k == n - 1);
		end
	endtask

	// Mostly short sets near the trial average, so that the first pass keeps
	// something and all four passes do real work; a quarter are centred far
	// away to drive the rejection paths. Runs until target items are queued.
	task automatic random_sets(input int unsigned target);
		int unsigned n;
		logic [31:0] centre;
		while (queued_items < target) begin
			n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12)
				: $urandom_range(13, 60);
			if ($urandom_range(0, 99) < 75)
				centre = around(trial_copy, 40);
			else
				centre = $urandom() >> $urandom_range(0, 31);
			queue_set(n, centre, $urandom_range(0, 80), $urandom_range(0, 30));
		end
	endtask

	// Register writes happen only with the block idle: the write edge comes
	// first, and samples are queued only after write enable has gone low.
	task automatic write_trial(input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Waits until every queued transaction has been taken and every result
	// has come back, then lets the block settle.
	task automatic wait_idle();
		while (pending_samples.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets against a trial average of 1000: a lone sample, the
		// field extremes mixed with ordinary values, a set of only a zero,
		// samples at exactly the ratio limit on both sides, and a pair just
		// inside it.
		write_trial(32'd1000);
		queue_item(32'd1000, 1'b1);
		queue_item(32'd0, 1'b0);
		queue_item(32'hFFFF_FFFF, 1'b0);
		queue_item(32'd1000, 1'b0);
		queue_item(32'd1200, 1'b0);
		queue_item(32'd800, 1'b1);
		queue_item(32'd0, 1'b1);
		queue_item(32'd5000, 1'b1);
		queue_item(32'd200, 1'b1);
		queue_item(32'd201, 1'b0);
		queue_item(32'd4999, 1'b1);
		wait_idle();

		// A zero reference average can accept nothing at all.
		write_trial(32'd0);
		queue_item(32'd1000, 1'b0);
		queue_item(32'd2000, 1'b1);
		wait_idle();

		// Largest reference and samples: widest sums and products.
		write_trial(32'hFFFF_FFFF);
		queue_item(32'hFFFF_FFFF, 1'b0);
		queue_item(32'hFFFF_FFFE, 1'b0);
		queue_item(32'hFFFF_FFF0, 1'b1);
		wait_idle();

		// Random sets, first back to back, then with the sender idling.
		write_trial($urandom());
		sender_idle_pct = 0;
		random_sets(220);
		wait_idle();

		write_trial($urandom());
		sender_idle_pct = 46;
		random_sets(440);
		wait_idle();

		// Small averages, where truncation and the ratio limits bite hardest.
		write_trial($urandom_range(1, 64));
		sender_idle_pct = 34;
		random_sets(650);
		wait_idle();

		// One set two samples past the store size: the last two samples are dropped,
		// the overflow flag must show, and a tight cluster keeps the whole
		// store, giving the largest possible count.
		write_trial(32'h8000_0000);
		queue_set(STORE_DEPTH + 2, 32'h8000_0000, 10, 0);
		wait_idle();

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### outlier_rejecting_mean.f
hdl/orm_pkg.sv
hdl/orm_ram.sv
hdl/orm_div.sv
hdl/orm_datapath.sv
hdl/orm_ctrl.sv
hdl/outlier_rejecting_mean.sv
tb/tb_outlier_rejecting_mean.sv
